/* src/fys_pkg.sv */
// fys_pkg: shared widths, constants and the controller/datapath command and status types
// for the card shuffler; no dependencies
package fys_pkg;

    localparam int CARD_W = 8;
    localparam int POS_W  = 7;
    localparam int DIV_W  = 8;

    localparam logic [CARD_W-1:0] DECK_SIZE_RESET = 8'd102;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic div1_start;
        logic div2_start;
        logic j_load;
        logic rd_i;
        logic rd_j;
        logic a_load;
        logic swap_wr;
        logic wr_i;
        logic emit1;
        logic rd_l;
        logic ldat;
        logic emit2;
    } fys_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic out_free;
        logic is_last;
    } fys_sts_t;

endpackage

/* src/fys_divider.sv */
// fys_divider: iterative unsigned restoring divider, one quotient bit per cycle
// depends on fys_pkg
module fys_divider import fys_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W+1:0] diff;
    logic             sel;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, div_reg};
    assign sel       = ~diff[DIV_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = sel ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], sel};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/fys_datapath.sv */
// fys_datapath: deck memory, step and draw registers, shared divider and output register
// depends on fys_pkg and fys_divider
module fys_datapath import fys_pkg::*; #(
    parameter int MAX_CARDS = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fys_cmd_t          cmd,
    output fys_sts_t          sts,
    input  logic              cfg_valid,
    input  logic [CARD_W-1:0] cfg_deck_size,
    input  logic [CARD_W-1:0] s_random_value,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [POS_W-1:0]  m_position,
    output logic [POS_W-1:0]  m_card,
    output logic              m_last_of_shuffle
);

    localparam int AW    = $clog2(MAX_CARDS);
    localparam int IDX_W = (AW > CARD_W) ? AW : CARD_W;

    function automatic logic [AW-1:0] to_addr(input logic [CARD_W-1:0] x);
        logic [IDX_W-1:0] ext;
        ext = IDX_W'(x);
        return ext[AW-1:0];
    endfunction

    logic [CARD_W-1:0] deck [MAX_CARDS];

    logic [CARD_W-1:0] size_reg;
    logic [CARD_W-1:0] step_reg, step_next;
    logic [CARD_W-1:0] r_reg;
    logic [CARD_W-1:0] j_reg;
    logic [CARD_W-1:0] a_reg;
    logic [CARD_W-1:0] b_reg;
    logic [CARD_W-1:0] l_reg;
    logic [CARD_W-1:0] rd_data_reg;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;

    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  m_position_reg;
    logic [POS_W-1:0]  m_card_reg;
    logic              m_last_reg;

    logic [CARD_W-1:0] n_cards;
    logic [CARD_W-1:0] n_minus1;
    logic [CARD_W-1:0] r_clamped;
    logic [CARD_W:0]   j_sum;
    logic [CARD_W-1:0] j_next;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CARD_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;

    // active card count, clamped to 2..MAX_CARDS
    always_comb begin
        if (size_reg < CARD_W'(2)) begin
            n_cards = CARD_W'(2);
        end else if (int'(size_reg) > MAX_CARDS) begin
            n_cards = CARD_W'(MAX_CARDS);
        end else begin
            n_cards = size_reg;
        end
    end

    assign n_minus1  = n_cards - 1'b1;
    assign r_clamped = (s_random_value > n_cards) ? n_cards : s_random_value;

    // divider shared by both divisions
    assign div_start    = cmd.div1_start | cmd.div2_start;
    assign div_dividend = cmd.div2_start ? r_reg : n_cards;
    assign div_divisor  = cmd.div2_start ? (div_quo + 1'b1) : (n_cards - step_reg);

    fys_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign j_sum  = {1'b0, step_reg} + {1'b0, div_quo};
    assign j_next = (j_sum >= {1'b0, n_cards}) ? n_minus1 : j_sum[CARD_W-1:0];

    // memory port selection
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.clr_step) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = CARD_W'(clr_cnt_reg);
        end else if (cmd.swap_wr) begin
            we    = 1'b1;
            waddr = to_addr(j_reg);
            wdata = a_reg;
        end else if (cmd.wr_i) begin
            // fixed entry returns to identity for the next shuffle
            we    = 1'b1;
            waddr = to_addr(step_reg);
            wdata = step_reg;
        end else if (cmd.ldat) begin
            we    = 1'b1;
            waddr = to_addr(n_minus1);
            wdata = n_minus1;
        end
    end

    always_comb begin
        re    = cmd.rd_i | cmd.rd_j | cmd.rd_l;
        raddr = to_addr(step_reg);
        if (cmd.rd_j) begin
            raddr = to_addr(j_reg);
        end else if (cmd.rd_l) begin
            raddr = to_addr(n_minus1);
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            deck[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= deck[raddr];
        end
    end

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (cfg_valid) begin
            clr_cnt_next = '0;
        end else if (cmd.clr_step) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        step_next = step_reg;
        if (cfg_valid) begin
            step_next = '0;
        end else if (cmd.emit2) begin
            step_next = '0;
        end else if (cmd.emit1 && !sts.is_last) begin
            step_next = step_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit1 || cmd.emit2) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= DECK_SIZE_RESET;
            step_reg    <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                size_reg <= cfg_deck_size;
            end
            step_reg    <= step_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        if (cmd.load_in) begin
            r_reg <= r_clamped;
        end
        if (cmd.j_load) begin
            j_reg <= j_next;
        end
        if (cmd.a_load) begin
            a_reg <= rd_data_reg;
        end
        if (cmd.swap_wr) begin
            b_reg <= rd_data_reg;
        end
        if (cmd.ldat) begin
            l_reg <= rd_data_reg;
        end
        if (cmd.emit1) begin
            m_position_reg <= step_reg[POS_W-1:0];
            m_card_reg     <= b_reg[POS_W-1:0];
            m_last_reg     <= 1'b0;
        end else if (cmd.emit2) begin
            m_position_reg <= n_minus1[POS_W-1:0];
            m_card_reg     <= l_reg[POS_W-1:0];
            m_last_reg     <= 1'b1;
        end
    end

    assign sts.clr_done = (clr_cnt_reg == AW'(MAX_CARDS - 1));
    assign sts.div_done = div_done;
    assign sts.out_free = ~m_valid_reg | m_ready;
    assign sts.is_last  = (step_reg == (n_cards - CARD_W'(2)));

    assign m_valid           = m_valid_reg;
    assign m_position        = m_position_reg;
    assign m_card            = m_card_reg;
    assign m_last_of_shuffle = m_last_reg;

endmodule

/* src/fys_ctrl.sv */
// fys_ctrl: sequencing state machine for clearing, the two divisions, the swap and the beats out
// depends on fys_pkg
module fys_ctrl import fys_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     cfg_valid,
    input  fys_sts_t sts,
    output fys_cmd_t cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV1  = 4'd2;
    localparam logic [3:0] ST_DIV2  = 4'd3;
    localparam logic [3:0] ST_RDI   = 4'd4;
    localparam logic [3:0] ST_RDJ   = 4'd5;
    localparam logic [3:0] ST_SWP   = 4'd6;
    localparam logic [3:0] ST_WRI   = 4'd7;
    localparam logic [3:0] ST_EMIT1 = 4'd8;
    localparam logic [3:0] ST_RDL   = 4'd9;
    localparam logic [3:0] ST_LDAT  = 4'd10;
    localparam logic [3:0] ST_EMIT2 = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in    = 1'b1;
                    cmd.div1_start = 1'b1;
                    state_next     = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (sts.div_done) begin
                    cmd.div2_start = 1'b1;
                    state_next     = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (sts.div_done) begin
                    cmd.j_load = 1'b1;
                    state_next = ST_RDI;
                end
            end
            ST_RDI: begin
                cmd.rd_i   = 1'b1;
                state_next = ST_RDJ;
            end
            ST_RDJ: begin
                cmd.rd_j   = 1'b1;
                cmd.a_load = 1'b1;
                state_next = ST_SWP;
            end
            ST_SWP: begin
                cmd.swap_wr = 1'b1;
                state_next  = ST_WRI;
            end
            ST_WRI: begin
                cmd.wr_i   = 1'b1;
                state_next = ST_EMIT1;
            end
            ST_EMIT1: begin
                if (sts.out_free) begin
                    cmd.emit1  = 1'b1;
                    state_next = sts.is_last ? ST_RDL : ST_IDLE;
                end
            end
            ST_RDL: begin
                cmd.rd_l   = 1'b1;
                state_next = ST_LDAT;
            end
            ST_LDAT: begin
                cmd.ldat   = 1'b1;
                state_next = ST_EMIT2;
            end
            ST_EMIT2: begin
                if (sts.out_free) begin
                    cmd.emit2  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        // a new deck size restarts the identity sweep
        if (cfg_valid) begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/fisher_yates_shuffle_core.sv */
// fisher_yates_shuffle_core: card shuffler, one deck position fixed per random draw
// depends on fys_pkg, fys_ctrl and fys_datapath
//
// Usage:
//   cfg channel: one beat writes deck_size (clamped to 2..MAX_CARDS); cfg_ready is always
//   high. Each write refills the deck with the identity and restarts the shuffle at
//   position 0, by a sweep over all MAX_CARDS entries during which s_ready is low.
//   s channel: one beat per random draw, values above the deck size are saturated.
//   m channel: one beat per draw giving the fixed position and its card; the draw for
//   the second-to-last position gives a second beat for the last position with
//   m_last_of_shuffle high, after which the next shuffle starts from the identity.
//   Timing: each draw runs two 8-bit divisions on one shared divider (one quotient
//   bit per cycle), then the read/write swap on the deck memory, before s_ready
//   returns; the final draw of a shuffle also reads and emits the last position.
//   A stalled receiver holds the result in the output register; the next draw is
//   still accepted and the block waits only when it has a new result to hand over.
//   Reset: synchronous active-low aresetn sets deck_size to 102 and runs the sweep.
module fisher_yates_shuffle_core import fys_pkg::*; #(
    parameter int MAX_CARDS = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CARD_W-1:0] cfg_deck_size,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CARD_W-1:0] s_random_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_position,
    output logic [POS_W-1:0]  m_card,
    output logic              m_last_of_shuffle
);

    fys_cmd_t cmd;
    fys_sts_t sts;

    assign cfg_ready = 1'b1;

    fys_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    fys_datapath #(
        .MAX_CARDS (MAX_CARDS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_valid         (cfg_valid),
        .cfg_deck_size     (cfg_deck_size),
        .s_random_value    (s_random_value),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_position        (m_position),
        .m_card            (m_card),
        .m_last_of_shuffle (m_last_of_shuffle)
    );

endmodule

/* tb/fisher_yates_shuffle_core_test.sv */
// fisher_yates_shuffle_core_test: self-checking bench for the card shuffler, with a
// scoreboard class that replays each draw on its own deck copy and checks every m beat
// depends on fys_pkg and fisher_yates_shuffle_core
module fisher_yates_shuffle_core_test;
    import fys_pkg::*;

    localparam int MAX_CARDS      = 128;
    localparam int ITEMS          = 1950;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] card;
        logic             last_of_shuffle;
    } fixed_card_t;

    class shuffle_scoreboard;
        logic [POS_W-1:0] deck [MAX_CARDS];
        int unsigned      cards;
        int unsigned      step_pos;
        int unsigned      errors;
        int unsigned      draws;
        int unsigned      results;
        fixed_card_t      fixed_q [$];

        function void restart();
            for (int k = 0; k < MAX_CARDS; k++) deck[k] = POS_W'(k);
            step_pos = 0;
        endfunction

        function void set_size(logic [CARD_W-1:0] size);
            if (size < 2) cards = 2;
            else if (size > MAX_CARDS) cards = MAX_CARDS;
            else cards = size;
            restart();
        endfunction

        function int unsigned pending();
            return fixed_q.size();
        endfunction

        function void note_draw(logic [CARD_W-1:0] value);
            int unsigned      r;
            int unsigned      i;
            int unsigned      j;
            int unsigned      d;
            logic [POS_W-1:0] t;
            fixed_card_t      fc;
            draws++;
            r = value;
            if (r > cards) r = cards;
            if (step_pos > cards - 2) restart();
            i = step_pos;
            d = cards / (cards - i) + 1;
            j = i + r / d;
            if (j >= cards) j = cards - 1;
            t       = deck[j];
            deck[j] = deck[i];
            deck[i] = t;
            fc.position        = POS_W'(i);
            fc.card            = deck[i];
            fc.last_of_shuffle = 1'b0;
            fixed_q.push_back(fc);
            if (i == cards - 2) begin
                fc.position        = POS_W'(cards - 1);
                fc.card            = deck[cards - 1];
                fc.last_of_shuffle = 1'b1;
                fixed_q.push_back(fc);
                restart();
            end else begin
                step_pos = i + 1;
            end
        endfunction

        function void check_result(logic [POS_W-1:0] position, logic [POS_W-1:0] card,
                                   logic last_of_shuffle);
            fixed_card_t want;
            results++;
            if (fixed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, position %0d card %0d last %0b",
                         $time, position, card, last_of_shuffle);
                return;
            end
            want = fixed_q.pop_front();
            if (position !== want.position) begin
                errors++;
                $display("%0t: position expected %0d actual %0d",
                         $time, want.position, position);
            end
            if (card !== want.card) begin
                errors++;
                $display("%0t: card expected %0d actual %0d", $time, want.card, card);
            end
            if (last_of_shuffle !== want.last_of_shuffle) begin
                errors++;
                $display("%0t: last_of_shuffle expected %0b actual %0b",
                         $time, want.last_of_shuffle, last_of_shuffle);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CARD_W-1:0] cfg_deck_size;
    logic              s_valid;
    logic              s_ready;
    logic [CARD_W-1:0] s_random_value;
    logic              m_valid;
    logic              m_ready;
    logic [POS_W-1:0]  m_position;
    logic [POS_W-1:0]  m_card;
    logic              m_last_of_shuffle;

    shuffle_scoreboard sb;
    int unsigned       idle_pct;
    bit                calm_tail;
    int unsigned       stall_cycles;
    int unsigned       size_writes;

    fisher_yates_shuffle_core #(
        .MAX_CARDS(MAX_CARDS)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_deck_size     (cfg_deck_size),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_random_value    (s_random_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_position        (m_position),
        .m_card            (m_card),
        .m_last_of_shuffle (m_last_of_shuffle)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.set_size(cfg_deck_size);
                size_writes++;
            end
            if (s_valid && s_ready) sb.note_draw(s_random_value);
            if (m_valid && m_ready) sb.check_result(m_position, m_card, m_last_of_shuffle);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, stall_cycles);
                $display("fisher_yates_shuffle_core: mismatch");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (calm_tail || $urandom_range(0, 99) >= idle_pct) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    task automatic push_draw(input logic [CARD_W-1:0] value);
        if (!calm_tail && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_random_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_size(input logic [CARD_W-1:0] size);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cfg_valid     <= 1'b1;
        cfg_deck_size <= size;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CARD_W-1:0] size;
        int unsigned       n_eff;
        int unsigned       count;
        int unsigned       phase;
        int unsigned       sel;
        logic [CARD_W-1:0] draw;

        sb = new;
        sb.set_size(DECK_SIZE_RESET);
        idle_pct       = 20;
        calm_tail      = 1'b0;
        stall_cycles   = 0;
        size_writes    = 0;
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_deck_size  <= '0;
        s_valid        <= 1'b0;
        s_random_value <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size, saturating and boundary draws
        push_draw(8'd0);
        push_draw(8'd102);
        push_draw(8'd255);
        push_draw(8'd128);
        push_draw(8'd1);
        push_draw(8'd103);
        push_draw(8'd170);
        push_draw(8'd85);
        // smallest decks of two and three cards; with two, each draw completes a shuffle
        write_size(8'd2);
        push_draw(8'd0);
        push_draw(8'd1);
        push_draw(8'd2);
        push_draw(8'd255);
        write_size(8'd3);
        push_draw(8'd0);
        push_draw(8'd3);
        push_draw(8'd3);
        push_draw(8'd4);
        // sizes below two and above the deck store are clamped
        write_size(8'd0);
        push_draw(8'd0);
        push_draw(8'd2);
        write_size(8'd1);
        push_draw(8'd1);
        write_size(8'd255);
        push_draw(8'd255);
        push_draw(8'd0);
        push_draw(8'd128);

        phase = 0;
        while (sb.draws < ITEMS) begin
            if (sb.draws > ITEMS - 150) calm_tail = 1'b1;
            sel = $urandom_range(0, 9);
            if (phase == 0) size = 8'd128;
            else if (sel < 6) size = CARD_W'($urandom_range(2, 16));
            else if (sel < 8) size = CARD_W'($urandom_range(17, 127));
            else begin
                case ($urandom_range(0, 4))
                    0: size = 8'd0;
                    1: size = 8'd1;
                    2: size = 8'd2;
                    3: size = 8'd128;
                    default: size = CARD_W'($urandom_range(129, 255));
                endcase
            end
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 20;
                default: idle_pct = 50;
            endcase
            write_size(size);
            n_eff = sb.cards;
            if (n_eff > 32) count = n_eff - 1;
            else count = (n_eff - 1) * $urandom_range(1, 3);
            // cut short now and then, the next size write restarts the shuffle
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, n_eff - 1);
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 9) == 0) draw = CARD_W'($urandom_range(0, 255));
                else draw = CARD_W'($urandom_range(0, n_eff));
                push_draw(draw);
            end
            phase++;
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d draws and %0d result beats over %0d deck size writes",
                 sb.draws, sb.results, size_writes);
        $display("%0d random phases, deck sizes 0 to 255 including clamped values", phase);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("fisher_yates_shuffle_core: match");
        else
            $display("fisher_yates_shuffle_core: mismatch");
        $finish;
    end

endmodule
